@@ hdl/c8_pkg.sv @@
// Shared types, codes and constants for the CHIP-8 instruction core.
// Used by c8_alu and chip8_instruction_core; depends on nothing.
`timescale 1ns / 1ps
package c8_pkg;

	localparam int MemAw   = 12;
	localparam int ScrAw   = 8;
	localparam logic [11:0] PcReset = 12'h200;
	localparam logic [15:0] OpCls   = 16'h00E0;
	localparam logic [15:0] OpRet   = 16'h00EE;

	typedef enum logic [1:0] {
		FN_MEM_WR  = 2'd0,
		FN_EXEC    = 2'd1,
		FN_SCR_RD  = 2'd2,
		FN_REG_RD  = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
		ALU_SUB, ALU_SHR, ALU_RSB, ALU_SHL
	} alu_op_t;

	typedef struct packed {
		logic [7:0] val;
		logic       flag;
		logic       eq;
	} alu_res_t;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_SCR_RD, ST_F_HI, ST_F_LO, ST_F_OP, ST_RD_X, ST_RD_Y,
		ST_EXEC, ST_CLS, ST_D_MEM, ST_D_MWAIT, ST_D_RA, ST_D_WA, ST_D_WB, ST_D_END,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [11:0] address;
		logic [7:0]  data;
	} cmd_t;

	typedef struct packed {
		logic [11:0] program_counter;
		logic [15:0] executed_opcode;
		logic [7:0]  read_data;
		logic        draw_done;
		logic        collision;
		logic        unknown_op;
	} res_t;

endpackage

@@ hdl/c8_mem.sv @@
// Simple dual-port RAM, one write and one registered read per cycle.
// Depends on nothing; holds main memory and the screen.
`timescale 1ns / 1ps
module c8_mem #(
	parameter int AW = 12,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ hdl/c8_alu.sv @@
// Shared 8-bit arithmetic, logic, shift and compare unit.
// Depends on c8_pkg.
`timescale 1ns / 1ps
module c8_alu import c8_pkg::*; (
	input  alu_op_t    op,
	input  logic [7:0] a,
	input  logic [7:0] b,
	output alu_res_t   res
);
	logic [8:0] sum;
	logic [8:0] dif;
	logic [8:0] rdif;

	always_comb begin
		sum  = {1'b0, a} + {1'b0, b};
		dif  = {1'b0, a} - {1'b0, b};
		rdif = {1'b0, b} - {1'b0, a};
		res.eq   = (a == b);
		res.flag = 1'b0;
		res.val  = b;
		case (op)
			ALU_MOV: res.val = b;
			ALU_OR:  res.val = a | b;
			ALU_AND: res.val = a & b;
			ALU_XOR: res.val = a ^ b;
			ALU_ADD: begin
				res.val  = sum[7:0];
				res.flag = sum[8];
			end
			ALU_SUB: begin
				res.val  = dif[7:0];
				res.flag = ~dif[8];
			end
			ALU_SHR: begin
				res.val  = {1'b0, a[7:1]};
				res.flag = a[0];
			end
			ALU_RSB: begin
				res.val  = rdif[7:0];
				res.flag = ~rdif[8];
			end
			ALU_SHL: begin
				res.val  = {a[6:0], 1'b0};
				res.flag = a[7];
			end
			default: res.val = b;
		endcase
	end
endmodule

@@ hdl/chip8_instruction_core.sv @@
// Handles memory write, register read, screen read and execute, including draw DXYN
// and clear screen. One item at a time; the sequencer and the single-read-port memories
// set the rate. After reset a pass zeroes main memory and the screen while cmd_stall
// stays high. pc resets to 0x200; index, stack, stack pointer, V registers and
// res_valid reset to 0. Depends on c8_pkg, c8_mem, c8_alu.
`timescale 1ns / 1ps
module chip8_instruction_core import c8_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);
	state_t state_q, state_d;
	logic [11:0] clr_q, pc_q, index_q;
	logic [15:0] op_q;
	logic [7:0]  rd_q, vx_q, vy_q, spr_q, scr_a_q;
	logic [2:0]  shf_q;
	logic [3:0]  row_q, sp_q, rsel;
	logic        draw_q, coll_q, unk_q, res_valid_q;
	res_t        res_q;
	logic [7:0]  regs_q [16];
	logic [11:0] stack_q [16];

	logic              mem_we, scr_we;
	logic [MemAw-1:0]  mem_wa, mem_ra;
	logic [ScrAw-1:0]  scr_wa, scr_ra, scr_b;
	logic [7:0]        mem_wd, mem_rd, scr_wd, scr_rd, regs_rd, mask_a, mask_b, alu_b;
	logic [15:0]       mask_w;
	logic [4:0]        py;
	alu_op_t           alu_op;
	alu_res_t          alu;
	logic              alu_ok, accept;

	wire [3:0]  nib = op_q[15:12];
	wire [3:0]  xi  = op_q[11:8];
	wire [3:0]  yi  = op_q[7:4];
	wire [7:0]  nn  = op_q[7:0];
	wire [11:0] nnn = op_q[11:0];
	wire [11:0] pc2 = pc_q + 12'd2;
	wire [11:0] pc4 = pc_q + 12'd4;

	c8_mem #(.AW(MemAw), .DW(8)) u_main (
		.clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd), .raddr(mem_ra), .rdata(mem_rd)
	);
	c8_mem #(.AW(ScrAw), .DW(8)) u_screen (
		.clk(clk), .we(scr_we), .waddr(scr_wa), .wdata(scr_wd), .raddr(scr_ra), .rdata(scr_rd)
	);
	c8_alu u_alu (.op(alu_op), .a(vx_q), .b(alu_b), .res(alu));

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE) || res_valid_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign mask_w = {spr_q, 8'h00} >> shf_q;
	assign mask_a = mask_w[15:8];
	assign mask_b = mask_w[7:0];
	assign scr_b  = {scr_a_q[7:3], scr_a_q[2:0] + 3'd1};
	assign py     = vy_q[4:0] + {1'b0, row_q};
	assign regs_rd = regs_q[rsel];

	always_comb begin
		alu_ok = 1'b1;
		alu_op = ALU_MOV;
		alu_b  = vy_q;
		if (nib inside {4'h3, 4'h4, 4'h6, 4'h7}) begin
			alu_b = nn;
		end
		if (nib == 4'h7) begin
			alu_op = ALU_ADD;
		end else begin
			case (op_q[3:0])
				4'h0: alu_op = ALU_MOV;
				4'h1: alu_op = ALU_OR;
				4'h2: alu_op = ALU_AND;
				4'h3: alu_op = ALU_XOR;
				4'h4: alu_op = ALU_ADD;
				4'h5: alu_op = ALU_SUB;
				4'h6: alu_op = ALU_SHR;
				4'h7: alu_op = ALU_RSB;
				4'hE: alu_op = ALU_SHL;
				default: alu_ok = 1'b0;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_wa  = cmd.address;
		mem_wd  = cmd.data;
		mem_ra  = pc_q;
		scr_we  = 1'b0;
		scr_wa  = scr_a_q;
		scr_wd  = 8'h00;
		scr_ra  = cmd.address[7:0];
		rsel    = cmd.address[3:0];
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = 8'h00;
				scr_we = 1'b1;
				scr_wa = clr_q[7:0];
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (func_t'(cmd.func))
						FN_MEM_WR: begin
							mem_we  = 1'b1;
							state_d = ST_DONE;
						end
						FN_EXEC:   state_d = ST_F_HI;
						FN_SCR_RD: state_d = ST_SCR_RD;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_SCR_RD: state_d = ST_DONE;
			ST_F_HI: state_d = ST_F_LO;
			ST_F_LO: begin
				mem_ra  = pc_q + 12'd1;
				state_d = ST_F_OP;
			end
			ST_F_OP: state_d = ST_RD_X;
			ST_RD_X: begin
				rsel    = (nib == 4'hB) ? 4'h0 : xi;
				state_d = ST_RD_Y;
			end
			ST_RD_Y: begin
				rsel    = yi;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				if (op_q == OpCls) begin
					state_d = ST_CLS;
				end else if (nib == 4'hD && op_q[3:0] != 4'h0) begin
					state_d = ST_D_MEM;
				end
			end
			ST_CLS: begin
				scr_we = 1'b1;
				scr_wa = clr_q[7:0];
				if (clr_q[7:0] == '1) begin
					state_d = ST_DONE;
				end
			end
			ST_D_MEM: begin
				mem_ra  = index_q + {8'h00, row_q};
				state_d = ST_D_MWAIT;
			end
			ST_D_MWAIT: state_d = ST_D_RA;
			ST_D_RA: begin
				scr_ra  = scr_a_q;
				state_d = ST_D_WA;
			end
			ST_D_WA: begin
				scr_we  = 1'b1;
				scr_wa  = scr_a_q;
				scr_wd  = scr_rd ^ mask_a;
				scr_ra  = scr_b;
				state_d = ST_D_WB;
			end
			ST_D_WB: begin
				scr_we  = 1'b1;
				scr_wa  = scr_b;
				scr_wd  = scr_rd ^ mask_b;
				state_d = (row_q + 4'd1 == op_q[3:0]) ? ST_D_END : ST_D_MEM;
			end
			ST_D_END: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			pc_q        <= PcReset;
			index_q     <= '0;
			sp_q        <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				regs_q[i]  <= '0;
				stack_q[i] <= '0;
			end
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: clr_q <= clr_q + 12'd1;
				ST_EXEC: begin
					case (nib)
						4'h0: begin
							if (op_q == OpCls) begin
								clr_q <= '0;
							end else if (op_q == OpRet) begin
								sp_q <= sp_q - 4'd1;
								pc_q <= stack_q[sp_q - 4'd1] + 12'd2;
							end
						end
						4'h1: pc_q <= nnn;
						4'h2: begin
							stack_q[sp_q] <= pc_q;
							sp_q <= sp_q + 4'd1;
							pc_q <= nnn;
						end
						4'h3, 4'h5: pc_q <= alu.eq ? pc4 : pc2;
						4'h4, 4'h9: pc_q <= alu.eq ? pc2 : pc4;
						4'h6, 4'h7: begin
							regs_q[xi] <= (nib == 4'h6) ? nn : alu.val;
							pc_q <= pc2;
						end
						4'h8: begin
							if (alu_ok) begin
								regs_q[xi] <= alu.val;
								if (op_q[3:0] inside {4'h4, 4'h5, 4'h6, 4'h7, 4'hE}) begin
									regs_q[15] <= {7'd0, alu.flag};
								end
								pc_q <= pc2;
							end
						end
						4'hA: begin
							index_q <= nnn;
							pc_q <= pc2;
						end
						4'hB: pc_q <= nnn + {4'h0, vx_q};
						4'hD: begin
							if (op_q[3:0] == 4'h0) begin
								regs_q[15] <= 8'h00;
								pc_q <= pc2;
							end
						end
						default: ;
					endcase
				end
				ST_CLS: begin
					clr_q <= clr_q + 12'd1;
					if (clr_q[7:0] == '1) begin
						pc_q <= pc2;
					end
				end
				ST_D_END: begin
					regs_q[15] <= {7'd0, coll_q};
					pc_q <= pc2;
				end
				ST_DONE: res_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q   <= '0;
				rd_q   <= (cmd.func == FN_REG_RD) ? regs_rd : 8'h00;
				draw_q <= 1'b0;
				coll_q <= 1'b0;
				unk_q  <= 1'b0;
			end
			ST_SCR_RD: rd_q <= scr_rd;
			ST_F_LO: op_q[15:8] <= mem_rd;
			ST_F_OP: op_q[7:0] <= mem_rd;
			ST_RD_X: vx_q <= regs_rd;
			ST_RD_Y: vy_q <= regs_rd;
			ST_EXEC: begin
				row_q <= '0;
				case (nib)
					4'h0: begin
						draw_q <= (op_q == OpCls);
						unk_q  <= (op_q != OpCls) && (op_q != OpRet);
					end
					4'h8: unk_q <= !alu_ok;
					4'hD: draw_q <= 1'b1;
					4'hC, 4'hE, 4'hF: unk_q <= 1'b1;
					default: ;
				endcase
			end
			ST_D_MWAIT: begin
				spr_q   <= mem_rd;
				scr_a_q <= {py, vx_q[5:3]};
				shf_q   <= vx_q[2:0];
			end
			ST_D_WA: coll_q <= coll_q | (|(scr_rd & mask_a));
			ST_D_WB: begin
				coll_q <= coll_q | (|(scr_rd & mask_b));
				row_q  <= row_q + 4'd1;
			end
			ST_DONE: begin
				res_q.program_counter <= pc_q;
				res_q.executed_opcode <= op_q;
				res_q.read_data       <= rd_q;
				res_q.draw_done       <= draw_q;
				res_q.collision       <= coll_q;
				res_q.unknown_op      <= unk_q;
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted item did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside completion");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_EXEC |=> $stable(sp_q))
		else $error("stack pointer moved outside execute");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.unknown_op |-> !res_q.draw_done && !res_q.collision)
		else $error("unknown opcode reported a draw");
endmodule
